// ===== rtl/core/b32e_pkg.sv =====
`timescale 1ns / 1ps

package b32e_pkg;

  // widths of the symbol path
  localparam int unsigned IDX_W  = 5;
  localparam int unsigned CHAR_W = 7;
  localparam int unsigned ACC_W  = 12;
  localparam int unsigned AL_W   = 15;

  // alphabet split point and ascii bases
  localparam logic [IDX_W-1:0]  NUM_LETTERS = 5'd26;
  localparam logic [CHAR_W-1:0] BASE_UPPER  = 7'd65;
  localparam logic [CHAR_W-1:0] BASE_DIGIT  = 7'd50;

  // one byte worth of symbols: up to three indices, count 1 to 3, message end
  typedef struct packed {
    logic [2:0][IDX_W-1:0] idx;
    logic [1:0]            cnt;
    logic                  eom;
  } job_t;

  // rfc 4648 alphabet, A-Z then 2-7
  function automatic logic [CHAR_W-1:0] sym_char(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] off;
    begin
      off = idx - NUM_LETTERS;
      if (idx < NUM_LETTERS) begin
        sym_char = BASE_UPPER + {2'b00, idx};
      end else begin
        sym_char = BASE_DIGIT + {2'b00, off};
      end
    end
  endfunction

endpackage

// ===== rtl/core/b32e_split.sv =====
`timescale 1ns / 1ps

module b32e_split (
  input  logic [3:0]        left_bits,
  input  logic [2:0]        left_cnt,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  output b32e_pkg::job_t    job,
  output logic [3:0]        left_bits_nxt,
  output logic [2:0]        left_cnt_nxt
);
  import b32e_pkg::*;

  logic [2:0]      cnt_c;
  logic [3:0]      held;
  logic [ACC_W-1:0] acc;
  logic [AL_W-1:0]  al;
  logic [3:0]      nbits;
  logic [1:0]      full;
  logic [2:0]      rem;
  logic [3:0]      rem_mask;

  // clamp count and drop stale bits above it
  always_comb begin
    cnt_c = (left_cnt > 3'd4) ? 3'd4 : left_cnt;
    held  = left_bits & ((4'd1 << cnt_c) - 4'd1);
    acc   = {held, data_byte};
    nbits = {1'b0, cnt_c} + 4'd8;
  end

  // left-align the held bits so symbols fall on fixed 5-bit slices
  always_comb begin
    al = {3'b000, acc} << (3'd4 - cnt_c);
    al = al << 3;
  end

  // full symbols and leftover count
  always_comb begin
    if (nbits >= 4'd10) begin
      full = 2'd2;
      rem  = 3'(nbits - 4'd10);
    end else begin
      full = 2'd1;
      rem  = 3'(nbits - 4'd5);
    end
    rem_mask = (4'd1 << rem) - 4'd1;
  end

  // job for the emitter and the carried bits
  always_comb begin
    job.idx[0] = al[14:10];
    job.idx[1] = al[9:5];
    job.idx[2] = al[4:0];
    job.eom    = end_of_message;
    job.cnt    = (end_of_message && (rem != 3'd0)) ? full + 2'd1 : full;
    if (end_of_message) begin
      left_bits_nxt = 4'd0;
      left_cnt_nxt  = 3'd0;
    end else begin
      left_bits_nxt = acc[3:0] & rem_mask;
      left_cnt_nxt  = rem;
    end
  end

endmodule

// ===== rtl/core/b32e_emit.sv =====
`timescale 1ns / 1ps

module b32e_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        job_load,
  input  b32e_pkg::job_t              job_in,
  output logic                        job_free,
  output logic                        sym_valid,
  input  logic                        sym_ready,
  output logic [b32e_pkg::CHAR_W-1:0] sym_char_o,
  output logic                        sym_last
);
  import b32e_pkg::*;

  logic              job_valid_r, job_valid_nxt;
  job_t              job_r;
  logic [1:0]        pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;
  logic              slot_free;
  logic              emit;
  logic              done;
  logic [IDX_W-1:0]  cur_idx;

  // one symbol per cycle into the output register while it is free or being taken
  always_comb begin
    slot_free = !out_valid_r || sym_ready;
    emit      = job_valid_r && slot_free;
    done      = emit && (pos_r == (job_r.cnt - 2'd1));
    job_free  = !job_valid_r || done;
    cur_idx   = job_r.idx[pos_r];
  end

  // job and position next values
  always_comb begin
    job_valid_nxt = job_valid_r;
    pos_nxt       = pos_r;
    if (job_load) begin
      job_valid_nxt = 1'b1;
      pos_nxt       = 2'd0;
    end else if (done) begin
      job_valid_nxt = 1'b0;
    end else if (emit) begin
      pos_nxt = pos_r + 2'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (sym_ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      pos_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (job_load) begin
      job_r <= job_in;
    end
    if (emit) begin
      out_char_r <= sym_char(cur_idx);
      out_last_r <= job_r.eom && done;
    end
  end

  assign sym_valid  = out_valid_r;
  assign sym_char_o = out_char_r;
  assign sym_last   = out_last_r;

endmodule

// ===== rtl/core/base32_stream_encoder_top.sv =====
`timescale 1ns / 1ps

// Unpadded base32 (rfc 4648 alphabet) stream encoder. One message byte enters
// per input beat, with in_tlast on the final byte of a message; symbols leave
// one per output beat as ascii in out_tdata, with out_tlast on the final
// symbol of the message. A byte is split into its 1 to 3 symbols in the cycle
// it is accepted, and the symbol emitter then moves one symbol a cycle into
// the output register whenever that register is free or being taken by
// out_tready. A byte has 1 or 2 symbols mid-message and up to 3 on the last
// byte, about 1.6 symbols per byte on average. The next byte is accepted in
// the cycle the current byte's last symbol is moved out. While a symbol waits
// on out_tready in the output register, one more byte can be accepted into
// the emitter.

module base32_stream_encoder_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_message
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] symbol_char, [7] zero
  output logic       out_tlast   // last_symbol
);
  import b32e_pkg::*;

  logic [3:0]        left_bits_r, left_bits_nxt;
  logic [2:0]        left_cnt_r, left_cnt_nxt;
  job_t              job;
  logic              job_free;
  logic              in_beat;
  logic [CHAR_W-1:0] sym_char_w;

  assign in_tready = job_free;
  assign in_beat   = in_tvalid && job_free;

  // split the incoming byte against the carried bits
  b32e_split u_split (
    .left_bits      (left_bits_r),
    .left_cnt       (left_cnt_r),
    .data_byte      (in_tdata),
    .end_of_message (in_tlast),
    .job            (job),
    .left_bits_nxt  (left_bits_nxt),
    .left_cnt_nxt   (left_cnt_nxt)
  );

  // carried bits update on each input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_bits_r <= 4'd0;
      left_cnt_r  <= 3'd0;
    end else if (in_beat) begin
      left_bits_r <= left_bits_nxt;
      left_cnt_r  <= left_cnt_nxt;
    end
  end

  // symbol emitter and output register
  b32e_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_load   (in_beat),
    .job_in     (job),
    .job_free   (job_free),
    .sym_valid  (out_tvalid),
    .sym_ready  (out_tready),
    .sym_char_o (sym_char_w),
    .sym_last   (out_tlast)
  );

  assign out_tdata = {1'b0, sym_char_w};

endmodule

// ===== rtl/core/b32e_checker.sv =====
`timescale 1ns / 1ps

module b32e_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // every symbol is in the base32 alphabet
  a_out_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata >= 8'd50 && out_tdata <= 8'd55) ||
                   (out_tdata >= 8'd65 && out_tdata <= 8'd90))
    else $error("symbol outside alphabet");

  // an accepted byte is followed by a valid output beat after the job and output registers
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##2 out_tvalid)
    else $error("accepted byte produced no symbol");

  // output channel empty after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind base32_stream_encoder_top b32e_checker u_b32e_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ===== sim/base32_stream_encoder_top_test.sv =====
`timescale 1ns / 1ps

module base32_stream_encoder_top_test;
  import b32e_pkg::*;

  // one expected output beat
  typedef struct packed {
    logic [CHAR_W-1:0] symbol;
    logic              last;
  } symbol_beat_t;

  // how the bytes of a generated message are filled
  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tlast;   // end_of_message
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [6:0] symbol_char, [7] zero
  logic       out_tlast;  // last_symbol

  base32_stream_encoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // encoder state mirrored by the testbench
  logic [3:0]   held_bits;
  logic [2:0]   held_count;
  symbol_beat_t expected_symbols[$];
  string        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ234567";

  int unsigned  bytes_sent;
  int unsigned  mismatches;
  bit           no_idle;

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // wait cycles before the next beat on either side
  function automatic int unsigned draw_gap();
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) != 0) begin
      gap = $urandom_range(0, 18);
    end
    return gap;
  endfunction

  // split one byte into its expected symbols and advance the held bits
  function automatic void predict_symbols(input logic [7:0] data, input logic eom);
    int unsigned count;
    int unsigned nbits;
    logic [3:0]  keep_mask;
    logic [11:0] acc;
    logic [11:0] shifted;
    logic [4:0]  idx;
    symbol_beat_t beat;
    count = (held_count > 3'd4) ? 4 : held_count;
    keep_mask = (4'd1 << count) - 4'd1;
    acc = {held_bits & keep_mask, data};
    nbits = count + 8;
    // emit the top five bits while a full symbol is held
    while (nbits >= 5) begin
      shifted = acc >> (nbits - 5);
      idx = shifted[4:0];
      nbits = nbits - 5;
      beat.symbol = CHAR_W'(alphabet[idx]);
      beat.last = eom && (nbits == 0);
      expected_symbols = {expected_symbols, beat};
    end
    if (eom) begin
      // zero filled remainder closes the message
      if (nbits > 0) begin
        shifted = acc << (5 - nbits);
        idx = shifted[4:0];
        beat.symbol = CHAR_W'(alphabet[idx]);
        beat.last = 1'b1;
        expected_symbols = {expected_symbols, beat};
      end
      held_bits = 4'd0;
      held_count = 3'd0;
    end else begin
      shifted = acc & ((12'd1 << nbits) - 12'd1);
      held_bits = shifted[3:0];
      held_count = nbits[2:0];
    end
  endfunction

  // drive one input beat and wait for it to be taken
  task automatic send_byte(input logic [7:0] data, input logic eom);
    int unsigned gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tlast  <= eom;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_symbols(data, eom);
    bytes_sent++;
  endtask

  // one complete message of the given length
  task automatic send_message(input int unsigned len, input fill_t fill);
    logic [7:0] data;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: data = 8'h00;
        FILL_ONES: data = 8'hFF;
        default:   data = 8'($urandom());
      endcase
      send_byte(data, i == len - 1);
    end
  endtask

  // compare one output beat with the oldest expected symbol
  task automatic check_symbol(input logic [7:0] data, input logic last);
    symbol_beat_t want;
    if (expected_symbols.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch: unexpected symbol data=%h last=%b", data, last);
      end
    end else begin
      want = expected_symbols.pop_front();
      if (data[CHAR_W-1:0] !== want.symbol || data[7] !== 1'b0 || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected data=%h last=%b, got data=%h last=%b",
                   {1'b0, want.symbol}, want.last, data, last);
        end
      end
    end
  endtask

  // output side: random back-pressure, every taken beat is checked
  initial begin : symbol_sink
    int unsigned stall;
    out_tready = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      check_symbol(out_tdata, out_tlast);
    end
  end

  // extremes, short lengths and a message ending on a symbol boundary
  task automatic test_directed();
    send_message(1, FILL_ZERO);
    send_message(1, FILL_ONES);
    send_message(5, FILL_ONES);
    send_message(5, FILL_ZERO);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
  endtask

  // random messages, some lengths on the five byte boundary
  task automatic test_random_messages();
    int unsigned len;
    fill_t       fill;
    while (bytes_sent < 350) begin
      if ($urandom_range(0, 3) == 0) begin
        len = 5 * $urandom_range(1, 2);
      end else begin
        len = $urandom_range(1, 12);
      end
      case ($urandom_range(0, 19))
        0:       fill = FILL_ZERO;
        1:       fill = FILL_ONES;
        default: fill = FILL_RANDOM;
      endcase
      no_idle = ($urandom_range(0, 4) == 0);
      send_message(len, fill);
    end
    no_idle = 1'b0;
  endtask

  // full rate on both sides, single byte messages mixed with short ones
  task automatic test_back_to_back();
    no_idle = 1'b1;
    while (bytes_sent < 420) begin
      if ($urandom_range(0, 1) == 0) begin
        send_message(1, FILL_RANDOM);
      end else begin
        send_message($urandom_range(2, 6), FILL_RANDOM);
      end
    end
    no_idle = 1'b0;
  endtask

  // reset, run the tests in turn, drain and report
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = 8'h00;
    in_tlast   = 1'b0;
    held_bits  = 4'd0;
    held_count = 3'd0;
    bytes_sent = 0;
    mismatches = 0;
    no_idle    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_messages();
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/b32e_pkg.sv
rtl/core/b32e_split.sv
rtl/core/b32e_emit.sv
rtl/core/base32_stream_encoder_top.sv
rtl/core/b32e_checker.sv
sim/base32_stream_encoder_top_test.sv
